// ----- design/rmcsc_pkg.sv -----
// ----------------------------------------------------------------------------
// rmcsc_pkg: shared types, constants and helpers for the RMC sentence checker
// Holds the scan state record, the result record, the character codes and
// the small character-class functions used by the per-character step logic.
// ----------------------------------------------------------------------------
package rmcsc_pkg;

	// Scan phases.
	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_PREFIX = 3'd1;
	localparam logic [2:0] PH_BODY   = 3'd2;
	localparam logic [2:0] PH_HEX1   = 3'd3;
	localparam logic [2:0] PH_HEX2   = 3'd4;

	// Error codes, first one recorded wins.
	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_PREFIX   = 3'd1;
	localparam logic [2:0] ERR_TIME     = 3'd2;
	localparam logic [2:0] ERR_STATUS   = 3'd3;
	localparam logic [2:0] ERR_NOSUM    = 3'd4;
	localparam logic [2:0] ERR_BADHEX   = 3'd5;
	localparam logic [2:0] ERR_MISMATCH = 3'd6;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_A      = 8'h41;
	localparam logic [7:0] CH_V      = 8'h56;

	localparam logic [2:0] PREFIX_LEN   = 3'd6;
	localparam logic [3:0] TIME_LEN     = 4'd10;
	localparam logic [3:0] TIME_DOT_POS = 4'd6;
	localparam logic [3:0] FIELD_MAX    = 4'd15;
	localparam logic [1:0] TALLY_MAX    = 2'd3;

	typedef struct packed {
		logic [2:0] phase;
		logic [2:0] prefix_position;
		logic [1:0] comma_tally;
		logic [3:0] field_length;
		logic       field_chars_ok;
		logic [7:0] running_xor;
		logic [3:0] high_nibble;
		logic [2:0] first_error;
	} scan_state_t;

	// Packed so that sentence_valid lands in the lowest bit.
	typedef struct packed {
		logic [7:0] received_sum;
		logic [7:0] computed_sum;
		logic [2:0] error_code;
		logic       sentence_valid;
	} verdict_t;

	// Expected character after '$' at each prefix position ("GPRMC,").
	function automatic logic [7:0] prefix_char(input logic [2:0] pos);
		logic [7:0] ch;
		unique case (pos)
			3'd0:    ch = 8'h47;
			3'd1:    ch = 8'h50;
			3'd2:    ch = 8'h52;
			3'd3:    ch = 8'h4D;
			3'd4:    ch = 8'h43;
			3'd5:    ch = CH_COMMA;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	// Bit 4 set means the character is not a hex digit.
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] h;
		if (is_digit(c)) begin
			h = {1'b0, c[3:0]};
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			h = {1'b0, c[3:0] + 4'd9};
		end else begin
			h = 5'h10;
		end
		return h;
	endfunction

	function automatic logic [2:0] note_error(input logic [2:0] cur, input logic [2:0] e);
		return (cur == ERR_NONE) ? e : cur;
	endfunction

endpackage

// ----- design/rmcsc_step.sv -----
// ----------------------------------------------------------------------------
// rmcsc_step: next-state and verdict logic for one received character
// Purely combinational: given the current scan state and one character it
// returns the next state and, when the sentence closes, the verdict.
// ----------------------------------------------------------------------------
module rmcsc_step (
	input  rmcsc_pkg::scan_state_t cur,
	input  logic [7:0]             rx_char,
	output rmcsc_pkg::scan_state_t nxt,
	output logic                   emit,
	output rmcsc_pkg::verdict_t    verdict
);

	always_comb begin
		rmcsc_pkg::scan_state_t st;
		logic                   do_body;
		logic                   eol;
		logic                   char_ok;
		logic [4:0]             hv;
		logic [7:0]             rsum;
		logic [1:0]             tally_new;

		st        = cur;
		do_body   = 1'b0;
		emit      = 1'b0;
		rsum      = 8'h00;
		eol       = (rx_char == rmcsc_pkg::CH_CR) || (rx_char == rmcsc_pkg::CH_LF);
		hv        = rmcsc_pkg::hex_value(rx_char);
		char_ok   = 1'b0;
		tally_new = cur.comma_tally;

		if (rx_char == rmcsc_pkg::CH_DOLLAR) begin
			st.phase           = rmcsc_pkg::PH_PREFIX;
			st.prefix_position = 3'd0;
			st.comma_tally     = 2'd0;
			st.field_length    = 4'd0;
			st.field_chars_ok  = 1'b1;
			st.running_xor     = 8'h00;
			st.high_nibble     = 4'd0;
			st.first_error     = rmcsc_pkg::ERR_NONE;
		end else begin
			unique case (cur.phase)
				rmcsc_pkg::PH_PREFIX: begin
					if (cur.prefix_position < rmcsc_pkg::PREFIX_LEN &&
					    rx_char == rmcsc_pkg::prefix_char(cur.prefix_position)) begin
						st.running_xor     = cur.running_xor ^ rx_char;
						st.prefix_position = cur.prefix_position + 3'd1;
						if (st.prefix_position == rmcsc_pkg::PREFIX_LEN) begin
							st.comma_tally    = 2'd1;
							st.field_length   = 4'd0;
							st.field_chars_ok = 1'b1;
							st.phase          = rmcsc_pkg::PH_BODY;
						end
					end else begin
						// A broken prefix is recorded, then the character is scanned as body.
						st.first_error = rmcsc_pkg::note_error(cur.first_error,
							rmcsc_pkg::ERR_PREFIX);
						st.phase = rmcsc_pkg::PH_BODY;
						do_body  = 1'b1;
					end
				end
				rmcsc_pkg::PH_BODY: begin
					do_body = 1'b1;
				end
				rmcsc_pkg::PH_HEX1, rmcsc_pkg::PH_HEX2: begin
					if (eol) begin
						st.first_error = rmcsc_pkg::note_error(cur.first_error,
							rmcsc_pkg::ERR_NOSUM);
						emit = 1'b1;
					end else if (hv[4]) begin
						st.first_error = rmcsc_pkg::note_error(cur.first_error,
							rmcsc_pkg::ERR_BADHEX);
						emit = 1'b1;
					end else if (cur.phase == rmcsc_pkg::PH_HEX1) begin
						st.high_nibble = hv[3:0];
						st.phase       = rmcsc_pkg::PH_HEX2;
					end else begin
						rsum = {cur.high_nibble, hv[3:0]};
						if (rsum != cur.running_xor) begin
							st.first_error = rmcsc_pkg::note_error(cur.first_error,
								rmcsc_pkg::ERR_MISMATCH);
						end
						emit = 1'b1;
					end
				end
				default: begin
					// Idle and unused codes ignore everything but '$'.
				end
			endcase

			if (do_body) begin
				if (eol || rx_char == rmcsc_pkg::CH_STAR) begin
					// The format fields are incomplete when the body ends early.
					if (st.comma_tally < 2'd2) begin
						st.first_error = rmcsc_pkg::note_error(st.first_error,
							rmcsc_pkg::ERR_TIME);
					end else if (st.comma_tally < rmcsc_pkg::TALLY_MAX) begin
						st.first_error = rmcsc_pkg::note_error(st.first_error,
							rmcsc_pkg::ERR_STATUS);
					end
					if (eol) begin
						st.first_error = rmcsc_pkg::note_error(st.first_error,
							rmcsc_pkg::ERR_NOSUM);
						emit = 1'b1;
					end else begin
						st.phase = rmcsc_pkg::PH_HEX1;
					end
				end else begin
					st.running_xor = st.running_xor ^ rx_char;
					if (rx_char == rmcsc_pkg::CH_COMMA) begin
						if (st.comma_tally < rmcsc_pkg::TALLY_MAX) begin
							tally_new      = st.comma_tally + 2'd1;
							st.comma_tally = tally_new;
							if (tally_new == 2'd2) begin
								if (st.field_length != rmcsc_pkg::TIME_LEN ||
								    !st.field_chars_ok) begin
									st.first_error = rmcsc_pkg::note_error(
										st.first_error, rmcsc_pkg::ERR_TIME);
								end
							end else if (tally_new == rmcsc_pkg::TALLY_MAX) begin
								if (st.field_length != 4'd1 || !st.field_chars_ok) begin
									st.first_error = rmcsc_pkg::note_error(
										st.first_error, rmcsc_pkg::ERR_STATUS);
								end
							end
						end
						st.field_length   = 4'd0;
						st.field_chars_ok = 1'b1;
					end else begin
						if (st.comma_tally == 2'd1) begin
							char_ok = (st.field_length == rmcsc_pkg::TIME_DOT_POS) ?
								(rx_char == rmcsc_pkg::CH_DOT) : rmcsc_pkg::is_digit(rx_char);
							if (st.field_length >= rmcsc_pkg::TIME_LEN || !char_ok) begin
								st.field_chars_ok = 1'b0;
							end
						end else if (st.comma_tally == 2'd2) begin
							if (st.field_length != 4'd0 ||
							    (rx_char != rmcsc_pkg::CH_A && rx_char != rmcsc_pkg::CH_V)) begin
								st.field_chars_ok = 1'b0;
							end
						end
						if (st.field_length < rmcsc_pkg::FIELD_MAX) begin
							st.field_length = st.field_length + 4'd1;
						end
					end
				end
			end

			if (emit) begin
				st.phase = rmcsc_pkg::PH_IDLE;
			end
		end

		nxt                    = st;
		verdict.sentence_valid = (st.first_error == rmcsc_pkg::ERR_NONE);
		verdict.error_code     = st.first_error;
		verdict.computed_sum   = st.running_xor;
		verdict.received_sum   = rsum;
	end

endmodule

// ----- design/rmc_sentence_checker.sv -----
// ----------------------------------------------------------------------------
// rmc_sentence_checker: streaming format and checksum checker for RMC sentences
// Scans received characters and gives one verdict word per sentence.
// ----------------------------------------------------------------------------
// The block takes one character per clock and gives one verdict word for
// each sentence that ends with a checksum, a bad checksum digit, or CR/LF;
// a '$' drops any sentence in progress without a verdict. Each character is
// handled combinationally by the step logic against the scan state
// registers, and the verdict appears on the output in the cycle after the
// closing character is accepted. The output register holds the verdict while
// the downstream side stalls; input is held off only while a verdict waits
// and is not being taken in the same cycle, so an unstalled stream runs at
// one character per cycle.
module rmc_sentence_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_char
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // [0] sentence_valid, [3:1] error_code,
	                               // [11:4] computed_sum, [19:12] received_sum, [23:20] zero
);

	rmcsc_pkg::scan_state_t state_q;
	rmcsc_pkg::scan_state_t state_nxt;
	rmcsc_pkg::verdict_t    verdict;
	rmcsc_pkg::verdict_t    out_q;
	logic                   emit;
	logic                   in_accept;
	logic                   out_valid_q;

	assign s_tready  = !out_valid_q || m_tready;
	assign in_accept = s_tvalid && s_tready;

	rmcsc_step u_step (
		.cur     (state_q),
		.rx_char (s_tdata),
		.nxt     (state_nxt),
		.emit    (emit),
		.verdict (verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase           <= rmcsc_pkg::PH_IDLE;
			state_q.prefix_position <= 3'd0;
			state_q.comma_tally     <= 2'd0;
			state_q.field_length    <= 4'd0;
			state_q.field_chars_ok  <= 1'b1;
			state_q.running_xor     <= 8'h00;
			state_q.high_nibble     <= 4'd0;
			state_q.first_error     <= rmcsc_pkg::ERR_NONE;
		end else if (in_accept) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_accept && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept && emit) begin
			out_q <= verdict;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, out_q};

	// A waiting verdict that is not taken blocks the input.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |-> !s_tready)
		else $error("input accepted while a verdict is stalled");

	// The valid flag agrees with the error code.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.sentence_valid == (out_q.error_code == rmcsc_pkg::ERR_NONE)))
		else $error("sentence_valid disagrees with error_code");

	// A clean verdict always carries matching sums.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.error_code == rmcsc_pkg::ERR_NONE) |->
		(out_q.computed_sum == out_q.received_sum))
		else $error("clean verdict with differing sums");

	// A dollar always restarts the prefix scan with a clean record.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && s_tdata == rmcsc_pkg::CH_DOLLAR) |=>
		(state_q.phase == rmcsc_pkg::PH_PREFIX && state_q.first_error == rmcsc_pkg::ERR_NONE))
		else $error("dollar did not restart the sentence");

	// The scanner leaves for idle exactly when a verdict is issued.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && emit) |=> (state_q.phase == rmcsc_pkg::PH_IDLE && out_valid_q))
		else $error("verdict issued without returning to idle");

endmodule
